// File: rtl/fpr_pkg.sv
// Package: shared constants and types of the framed packet receiver.
package fpr_pkg;

  localparam int MAX_PAYLOAD = 32;
  localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
  localparam int LEN_W       = 6;
  localparam int BYTE_W      = 8;

  localparam logic [1:0] REG_START = 2'd0;
  localparam logic [1:0] REG_END   = 2'd1;
  localparam logic [1:0] REG_LIMIT = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] start_byte;
    logic [BYTE_W-1:0] end_byte;
    logic [LEN_W-1:0]  length_limit;
  } fpr_cfg_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [BYTE_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } fpr_mem_req_t;

endpackage

// File: rtl/fpr_ram.sv
// Payload store: one write port, one read port, registered read data.
module fpr_ram import fpr_pkg::*; (
  input  logic              clk_i,
  input  fpr_mem_req_t      req_i,
  output logic [BYTE_W-1:0] rdata_o
);

  logic [BYTE_W-1:0] mem [MAX_PAYLOAD];
  logic [BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/fpr_ctrl.sv
// Frame parser and payload readout sequencer around the payload store.
module fpr_ctrl import fpr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fpr_cfg_t          cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [BYTE_W-1:0] in_byte_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic [ADDR_W-1:0] out_index_o,
  output logic [LEN_W-1:0]  out_len_o,
  output logic              out_last_o,
  output fpr_mem_req_t      mem_req_o,
  input  logic [BYTE_W-1:0] mem_rdata_i
);

  localparam logic [2:0] ST_HUNT = 3'd0;
  localparam logic [2:0] ST_LEN  = 3'd1;
  localparam logic [2:0] ST_DATA = 3'd2;
  localparam logic [2:0] ST_CHK  = 3'd3;
  localparam logic [2:0] ST_END  = 3'd4;
  localparam logic [2:0] ST_RD   = 3'd5;
  localparam logic [2:0] ST_LD   = 3'd6;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

  logic [2:0]        state_q, state_d;
  logic [LEN_W-1:0]  count_q, count_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [BYTE_W-1:0] run_q, run_d;
  logic [BYTE_W-1:0] rcv_q, rcv_d;
  logic [LEN_W-1:0]  idx_q, idx_d;
  logic              oval_q, oval_d;
  logic [BYTE_W-1:0] obyte_q, obyte_d;
  logic [ADDR_W-1:0] oidx_q, oidx_d;
  logic [LEN_W-1:0]  olen_q, olen_d;
  logic              olast_q, olast_d;

  logic              in_acc;
  logic              out_acc;
  logic [LEN_W-1:0]  limit;
  logic [LEN_W-1:0]  in_len;
  logic              is_last;

  assign in_ready_o = (state_q == ST_HUNT) || (state_q == ST_LEN) ||
                      (state_q == ST_DATA) || (state_q == ST_CHK) ||
                      (state_q == ST_END);
  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = oval_q && out_ready_i;
  assign limit   = (cfg_i.length_limit > MAX_LEN) ? MAX_LEN : cfg_i.length_limit;
  assign in_len  = in_byte_i[LEN_W-1:0];
  assign is_last = (idx_q + LEN_W'(1)) == len_q;

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    len_d   = len_q;
    run_d   = run_q;
    rcv_d   = rcv_q;
    idx_d   = idx_q;
    oval_d  = oval_q && !out_acc;
    obyte_d = obyte_q;
    oidx_d  = oidx_q;
    olen_d  = olen_q;
    olast_d = olast_q;

    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = count_q[ADDR_W-1:0];
    mem_req_o.wdata = in_byte_i;
    mem_req_o.raddr = idx_q[ADDR_W-1:0];

    case (state_q)
      ST_HUNT: begin
        if (in_acc && in_byte_i == cfg_i.start_byte) begin
          count_d = '0;
          run_d   = in_byte_i;
          state_d = ST_LEN;
        end
      end
      ST_LEN: begin
        if (in_acc) begin
          if (in_byte_i == '0 || in_byte_i[BYTE_W-1:LEN_W] != '0 || in_len > limit) begin
            state_d = ST_HUNT;
          end else begin
            len_d   = in_len;
            run_d   = run_q ^ in_byte_i;
            state_d = ST_DATA;
          end
        end
      end
      ST_DATA: begin
        if (in_acc) begin
          mem_req_o.we = 1'b1;
          run_d   = run_q ^ in_byte_i;
          count_d = count_q + LEN_W'(1);
          if (count_d >= len_q) begin
            state_d = ST_CHK;
          end
        end
      end
      ST_CHK: begin
        if (in_acc) begin
          rcv_d   = in_byte_i;
          state_d = ST_END;
        end
      end
      ST_END: begin
        if (in_acc) begin
          idx_d = '0;
          if (in_byte_i == cfg_i.end_byte && rcv_q == run_q) begin
            state_d = ST_RD;
          end else begin
            state_d = ST_HUNT;
          end
        end
      end
      ST_RD: begin
        if (!oval_q || out_acc) begin
          state_d = ST_LD;
        end
      end
      ST_LD: begin
        oval_d  = 1'b1;
        obyte_d = mem_rdata_i;
        oidx_d  = idx_q[ADDR_W-1:0];
        olen_d  = len_q;
        olast_d = is_last;
        idx_d   = idx_q + LEN_W'(1);
        state_d = is_last ? ST_HUNT : ST_RD;
      end
      default: begin
        state_d = ST_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HUNT;
      count_q <= '0;
      len_q   <= '0;
      run_q   <= '0;
      rcv_q   <= '0;
      idx_q   <= '0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      len_q   <= len_d;
      run_q   <= run_d;
      rcv_q   <= rcv_d;
      idx_q   <= idx_d;
      oval_q  <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    obyte_q <= obyte_d;
    oidx_q  <= oidx_d;
    olen_q  <= olen_d;
    olast_q <= olast_d;
  end

  assign out_valid_o = oval_q;
  assign out_byte_o  = obyte_q;
  assign out_index_o = oidx_q;
  assign out_len_o   = olen_q;
  assign out_last_o  = olast_q;

endmodule

// File: rtl/framed_packet_receiver.sv
// Top level: configuration registers, frame parser and payload store.
// After the end byte of a valid frame, each payload byte takes a store read,
// then an output load; the store read waits until the output register is free.
// Throughput: one input byte per cycle while parsing; input stalls during
// readout.
// Reset: asynchronous active low; parser returns to hunting, registers to
// start 0x02, end 0x03, limit 32. The payload store is not cleared.
module framed_packet_receiver import fpr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] payload_byte, [12:8] byte_index,
                                      // [18:13] frame_length, [23:19] zero
  output logic        m_axis_tlast    // last
);

  fpr_cfg_t          cfg_q;
  fpr_mem_req_t      mem_req;
  logic [BYTE_W-1:0] mem_rdata;
  logic [BYTE_W-1:0] out_byte;
  logic [ADDR_W-1:0] out_index;
  logic [LEN_W-1:0]  out_len;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte   <= 8'h02;
      cfg_q.end_byte     <= 8'h03;
      cfg_q.length_limit <= LEN_W'(32);
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_START: cfg_q.start_byte   <= pwdata[BYTE_W-1:0];
        REG_END:   cfg_q.end_byte     <= pwdata[BYTE_W-1:0];
        REG_LIMIT: cfg_q.length_limit <= pwdata[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_START: prdata = {24'd0, cfg_q.start_byte};
      REG_END:   prdata = {24'd0, cfg_q.end_byte};
      REG_LIMIT: prdata = {26'd0, cfg_q.length_limit};
      default:   prdata = '0;
    endcase
  end

  fpr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (out_byte),
    .out_index_o (out_index),
    .out_len_o   (out_len),
    .out_last_o  (m_axis_tlast),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  fpr_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  assign m_axis_tdata = {5'd0, out_len, out_index, out_byte};

endmodule
